// ===== hw/rtl/htd_pkg.sv =====
package htd_pkg;

   localparam int PIXEL_W     = 8;
   localparam int PHASE_W     = 5;
   localparam int MODE_W      = 2;
   localparam int LOG2_W      = 3;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;

   localparam int DEFAULT_MAX_DITHER_LOG2 = 5;

   localparam logic [PIXEL_W-1:0] RESET_FIXED_LEVEL = 8'd128;
   localparam logic [LOG2_W-1:0]  RESET_DITHER_LOG2 = 3'd1;
   localparam logic [PIXEL_W-1:0] PIXEL_WHITE       = 8'hFF;
   localparam logic [PIXEL_W-1:0] PIXEL_BLACK       = 8'h00;

   typedef enum logic [MODE_W-1:0] {
      MODE_FIXED  = 2'd0,
      MODE_RANDOM = 2'd1,
      MODE_DITHER = 2'd2
   } mode_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MODE        = 2'd0,
      CSR_FIXED_LEVEL = 2'd1,
      CSR_DITHER_LOG2 = 2'd2
   } csr_index_type;

   typedef struct packed {
      mode_type             mode;
      logic [PIXEL_W-1:0]   fixed_level;
      logic [LOG2_W-1:0]    dither_log2;
   } cfg_type;

   typedef struct packed {
      logic [PHASE_W-1:0] row;
      logic [PHASE_W-1:0] col;
   } phase_type;

   // one base-4 digit of the ordered-dither index from a row bit and a column bit
   function automatic logic [1:0] bayer_digit(input logic row_bit, input logic col_bit);
      logic [1:0] digit;
      case ({row_bit, col_bit})
         2'b00:   digit = 2'd1;
         2'b01:   digit = 2'd2;
         2'b10:   digit = 2'd3;
         2'b11:   digit = 2'd0;
         default: digit = 2'd0;
      endcase
      return digit;
   endfunction

endpackage

// ===== hw/rtl/htd_phase.sv =====
module htd_phase
   import htd_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      accept,
   input  logic      end_of_line,
   input  logic      end_of_frame,
   output phase_type phase
);

   phase_type phase_ff;
   phase_type phase_in;

   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         if (end_of_frame) begin
            phase_in.row = '0;
            phase_in.col = '0;
         end else if (end_of_line) begin
            phase_in.row = phase_ff.row + PHASE_W'(1);
            phase_in.col = '0;
         end else begin
            phase_in.col = phase_ff.col + PHASE_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
      end else begin
         phase_ff <= phase_in;
      end
   end

   assign phase = phase_ff;

   a_frame_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && end_of_frame) |=> (phase_ff.row == '0 && phase_ff.col == '0))
      else $error("phase not cleared at end of frame");

   a_line_steps: assert property (@(posedge clock) disable iff (reset)
      (accept && end_of_line && !end_of_frame) |=>
         (phase_ff.col == '0 && phase_ff.row == $past(phase_ff.row) + PHASE_W'(1)))
      else $error("row phase did not advance at end of line");

   a_idle_holds: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(phase_ff))
      else $error("phase moved without a request");

endmodule

// ===== hw/rtl/htd_decide.sv =====
module htd_decide
   import htd_pkg::*;
#(
   parameter int MAX_DITHER_LOG2 = DEFAULT_MAX_DITHER_LOG2
) (
   input  cfg_type              cfg,
   input  logic [PIXEL_W-1:0]   pixel,
   input  logic [PIXEL_W-1:0]   random_level,
   input  phase_type            phase,
   output logic                 dark
);

   localparam int KW = $clog2(MAX_DITHER_LOG2 + 1);
   localparam int DW = 2 * MAX_DITHER_LOG2;
   localparam int TW = DW + 11;
   localparam int SW = KW + 2;

   logic [MAX_DITHER_LOG2-1:0] row_bits;
   logic [MAX_DITHER_LOG2-1:0] col_bits;
   logic [DW-1:0]              full_entry;
   logic [DW-1:0]              entry;
   logic [KW-1:0]              k;
   logic [SW-1:0]              drop;
   logic [SW-1:0]              shift;
   logic [TW-1:0]              odd;
   logic [TW-1:0]              numer;
   logic [TW-1:0]              level;

   always_comb begin
      // phase bits above the counter width read as zero
      row_bits = MAX_DITHER_LOG2'(phase.row);
      col_bits = MAX_DITHER_LOG2'(phase.col);

      if (cfg.dither_log2 == '0) begin
         k = KW'(1);
      end else if (32'(cfg.dither_log2) > MAX_DITHER_LOG2) begin
         k = KW'(MAX_DITHER_LOG2);
      end else begin
         k = KW'(cfg.dither_log2);
      end

      // entry for the largest matrix; a smaller matrix keeps its top 2k bits
      for (int b = 0; b < MAX_DITHER_LOG2; b++) begin
         full_entry[2*(MAX_DITHER_LOG2-1-b) +: 2] = bayer_digit(row_bits[b], col_bits[b]);
      end
      drop  = SW'(DW) - SW'({k, 1'b0});
      entry = full_entry >> drop;

      // level = ((2d+1)*510 + 2^(2k+1)) >> (2k+2)
      odd   = TW'({entry, 1'b1});
      shift = SW'({k, 1'b0}) + SW'(2);
      numer = (odd << 9) - (odd << 1) + (TW'(1) << (shift - SW'(1)));
      level = numer >> shift;

      case (cfg.mode)
         MODE_RANDOM: dark = pixel < random_level;
         MODE_DITHER: dark = TW'(pixel) <= level;
         default:     dark = pixel < cfg.fixed_level;
      endcase
   end

endmodule

// ===== hw/rtl/halftone_threshold_dither_unit.sv =====
// An accepted request passes through an input register, which feeds the threshold
// compare, and then the output register, whose contents show on rsp_*; one pixel
// per clock is taken while the receiver does not hold off with rsp_stall.
// Reset (synchronous): pipeline empty, row/column phase 0, mode fixed,
// fixed level 128, dither log2 of 1.
module halftone_threshold_dither_unit
   import htd_pkg::*;
#(
   parameter int MAX_DITHER_LOG2 = DEFAULT_MAX_DITHER_LOG2
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [PIXEL_W-1:0]     req_pixel,
   input  logic [PIXEL_W-1:0]     req_random_level,
   input  logic                   req_end_of_line,
   input  logic                   req_end_of_frame,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [PIXEL_W-1:0]     rsp_out_pixel,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   logic               s1_valid_ff;
   logic               s1_valid_in;
   logic [PIXEL_W-1:0] s1_pixel_ff;
   logic [PIXEL_W-1:0] s1_random_ff;
   phase_type          s1_phase_ff;

   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic [PIXEL_W-1:0] rsp_pixel_ff;

   logic      advance;
   logic      req_accept;
   logic      dark;
   phase_type phase;

   // config registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_MODE:        cfg_in.mode        = mode_type'(csr_data[MODE_W-1:0]);
            CSR_FIXED_LEVEL: cfg_in.fixed_level = csr_data[PIXEL_W-1:0];
            CSR_DITHER_LOG2: cfg_in.dither_log2 = csr_data[LOG2_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode        <= MODE_FIXED;
         cfg_ff.fixed_level <= RESET_FIXED_LEVEL;
         cfg_ff.dither_log2 <= RESET_DITHER_LOG2;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // output register frees up when empty or being taken
   assign advance    = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = s1_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;

   htd_phase u_phase (
      .clock        (clock),
      .reset        (reset),
      .accept       (req_accept),
      .end_of_line  (req_end_of_line),
      .end_of_frame (req_end_of_frame),
      .phase        (phase)
   );

   htd_decide #(
      .MAX_DITHER_LOG2 (MAX_DITHER_LOG2)
   ) u_decide (
      .cfg          (cfg_ff),
      .pixel        (s1_pixel_ff),
      .random_level (s1_random_ff),
      .phase        (s1_phase_ff),
      .dark         (dark)
   );

   always_comb begin
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      rsp_valid_in = advance ? s1_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_pixel_ff  <= req_pixel;
         s1_random_ff <= req_random_level;
         s1_phase_ff  <= phase;
      end
      if (advance && s1_valid_ff) begin
         rsp_pixel_ff <= dark ? PIXEL_BLACK : PIXEL_WHITE;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_pixel = rsp_pixel_ff;

   a_binary_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_pixel_ff == PIXEL_BLACK || rsp_pixel_ff == PIXEL_WHITE))
      else $error("result pixel not black or white");

   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && rsp_valid_ff && rsp_stall))
      else $error("request stalled with room in the pipeline");

   a_s1_moves: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && advance) |=> rsp_valid_ff)
      else $error("input stage item lost on its way to the output register");

   a_accept_loads: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> s1_valid_ff)
      else $error("accepted request not held in input stage");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
   import htd_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int HOLD_AT      = 400;   // result count that starts the long receiver hold-off
   localparam int HOLD_CYCLES  = 80;
   localparam int PHASE_ITEMS  = 115;
   localparam int RANDOM_PHASES = 10;
   localparam logic [MODE_W-1:0]      MODE_UNUSED = 2'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED  = 2'd3;
   // base-4 digit of the matrix index, addressed by {row bit, column bit}
   localparam int unsigned BAYER_DIGIT [4] = '{1, 2, 3, 0};

   typedef struct {
      logic [PIXEL_W-1:0] pixel;
      logic [PIXEL_W-1:0] level;
      logic               eol;
      logic               eof;
   } pixel_req_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [PIXEL_W-1:0]     req_pixel = '0;
   logic [PIXEL_W-1:0]     req_random_level = '0;
   logic                   req_end_of_line = 1'b0;
   logic                   req_end_of_frame = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [PIXEL_W-1:0]     rsp_out_pixel;
   logic                   csr_write = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   // shadow copy of the block's registers and raster position
   logic [MODE_W-1:0]  cfg_mode  = MODE_FIXED;
   logic [PIXEL_W-1:0] cfg_fixed = RESET_FIXED_LEVEL;
   logic [LOG2_W-1:0]  cfg_log2  = RESET_DITHER_LOG2;
   logic [PHASE_W-1:0] row_phase = '0;
   logic [PHASE_W-1:0] col_phase = '0;

   pixel_req_type      req_queue [$];
   logic [PIXEL_W-1:0] expected_out [$];
   int                 req_total = 0;
   int                 rsp_seen = 0;
   int                 mismatches = 0;
   int                 settings_used = 0;
   int                 cycles = 0;
   int                 hold_left = 0;
   logic               rsp_hold = 1'b0;
   logic               calm = 1'b0;

   // raster generator state, kept across register changes
   int frame_width = 0;
   int rows_left = 0;
   int cols_left = 0;

   halftone_threshold_dither_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_pixel        (req_pixel),
      .req_random_level (req_random_level),
      .req_end_of_line  (req_end_of_line),
      .req_end_of_frame (req_end_of_frame),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_pixel    (rsp_out_pixel),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // ordered-dither threshold: round((d + 0.5) * 255 / N^2) in integers
   function automatic logic [PIXEL_W-1:0] dither_level(input logic [LOG2_W-1:0] log2,
                                                      input logic [PHASE_W-1:0] r,
                                                      input logic [PHASE_W-1:0] c);
      int unsigned       k;
      int unsigned       d;
      longint unsigned   num;
      longint unsigned   den;
      longint unsigned   t;
      k = log2;
      if (k < 1) k = 1;
      if (k > DEFAULT_MAX_DITHER_LOG2) k = DEFAULT_MAX_DITHER_LOG2;
      d = 0;
      for (int b = 0; b < k; b++)
         d += BAYER_DIGIT[{r[b], c[b]}] << (2 * (k - 1 - b));
      num = (2 * longint'(d) + 1) * 255;
      den = 64'd2 << (2 * k);
      t = (2 * num + den) / (2 * den);
      if (t > 255) t = 255;
      return PIXEL_W'(t);
   endfunction

   // judge one accepted pixel and step the raster position
   task automatic predict_halftone(input pixel_req_type item);
      logic dark;
      if (cfg_mode == MODE_RANDOM)
         dark = item.pixel < item.level;
      else if (cfg_mode == MODE_DITHER)
         dark = item.pixel <= dither_level(cfg_log2, row_phase, col_phase);
      else
         dark = item.pixel < cfg_fixed;
      expected_out = {expected_out, (dark ? PIXEL_BLACK : PIXEL_WHITE)};
      if (item.eof) begin
         row_phase = '0;
         col_phase = '0;
      end else if (item.eol) begin
         col_phase = '0;
         row_phase = row_phase + 1'b1;
      end else begin
         col_phase = col_phase + 1'b1;
      end
   endtask

   always @(posedge clock) begin : drive
      pixel_req_type item;
      logic          idle;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            item.pixel = req_pixel;
            item.level = req_random_level;
            item.eol   = req_end_of_line;
            item.eof   = req_end_of_frame;
            predict_halftone(item);
         end
         if (!req_valid || !req_stall) begin
            idle = !calm && !rsp_hold && ($urandom_range(99) < 27);
            if (!idle && req_queue.size() > 0) begin
               item = req_queue.pop_front();
               req_valid        <= 1'b1;
               req_pixel        <= item.pixel;
               req_random_level <= item.level;
               req_end_of_line  <= item.eol;
               req_end_of_frame <= item.eof;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : watch
      logic [PIXEL_W-1:0] want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            rsp_seen++;
            if (expected_out.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected result, expected none, got out_pixel %0d",
                        $time, rsp_out_pixel);
            end else begin
               want = expected_out.pop_front();
               if (rsp_out_pixel !== want) begin
                  mismatches++;
                  $display("%0t: out_pixel mismatch, expected %0d, got %0d",
                           $time, want, rsp_out_pixel);
               end
            end
            if (rsp_seen == HOLD_AT) hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_hold  <= 1'b1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_hold  <= 1'b0;
            rsp_stall <= !calm && ($urandom_range(99) < 27);
         end
      end
   end

   task automatic send(input int pixel, input int level, input bit eol, input bit eof);
      pixel_req_type item;
      item.pixel = PIXEL_W'(pixel);
      item.level = PIXEL_W'(level);
      item.eol   = eol;
      item.eof   = eof;
      req_queue = {req_queue, item};
      req_total++;
   endtask

   task automatic wait_all_results();
      while (rsp_seen != req_total) @(negedge clock);
   endtask

   // random bits above the register width must be dropped by the block
   function automatic logic [CSR_DATA_W-1:0] with_noise(input int value, input int bits);
      logic [CSR_DATA_W-1:0] keep;
      keep = CSR_DATA_W'((1 << bits) - 1);
      return (CSR_DATA_W'($urandom) & ~keep) | (CSR_DATA_W'(value) & keep);
   endfunction

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      case (index)
         CSR_MODE:        cfg_mode  = data[MODE_W-1:0];
         CSR_FIXED_LEVEL: cfg_fixed = data[PIXEL_W-1:0];
         CSR_DITHER_LOG2: cfg_log2  = data[LOG2_W-1:0];
         default:         ;
      endcase
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic configure(input int mode, input int fixed, input int log2);
      write_reg(CSR_MODE, with_noise(mode, MODE_W));
      write_reg(CSR_FIXED_LEVEL, CSR_DATA_W'(fixed));
      write_reg(CSR_DITHER_LOG2, with_noise(log2, LOG2_W));
      write_reg(CSR_UNUSED, CSR_DATA_W'($urandom));
      settings_used++;
      @(negedge clock);
   endtask

   // mostly whole rows and frames, some stray line and frame marks
   task automatic random_pixels(input int count);
      bit last_col;
      bit eof;
      for (int i = 0; i < count; i++) begin
         if (cols_left == 0) begin
            if (rows_left == 0) begin
               frame_width = ($urandom_range(99) < 80) ? $urandom_range(1, 6)
                                                       : $urandom_range(30, 40);
               rows_left = $urandom_range(1, 40);
            end
            cols_left = frame_width;
         end
         if ($urandom_range(99) < 8) begin
            send($urandom_range(255), $urandom_range(255), $urandom_range(1),
                 $urandom_range(1));
         end else begin
            last_col = (cols_left == 1);
            eof = last_col && (rows_left == 1);
            send($urandom_range(255), $urandom_range(255),
                 last_col && (!eof || $urandom_range(1)), eof);
            cols_left--;
            if (last_col) rows_left--;
         end
      end
   endtask

   initial begin : sequencer
      logic [MODE_W-1:0] phase_mode [RANDOM_PHASES];
      int phase_log2 [RANDOM_PHASES];
      int fixed;

      phase_mode = '{MODE_DITHER, MODE_FIXED, MODE_DITHER, MODE_RANDOM, MODE_DITHER,
         MODE_UNUSED, MODE_DITHER, MODE_FIXED, MODE_DITHER, MODE_RANDOM};
      phase_log2 = '{5, 0, 1, 7, 2, 6, 3, 4, 4, 5};

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset values: fixed threshold of 128
      send(127, 200, 0, 0);
      send(128, 0, 0, 0);
      send(0, 255, 0, 0);
      send(255, 0, 1, 0);
      wait_all_results();

      // random threshold: strict less-than, both ends
      configure(MODE_RANDOM, 128, 1);
      send(0, 0, 0, 0);
      send(0, 1, 0, 0);
      send(255, 255, 0, 0);
      send(254, 255, 1, 1);
      wait_all_results();

      // 2x2 matrix with a zero size code; pixels right at and just past thresholds
      configure(MODE_DITHER, 128, 0);
      send(96, 17, 0, 0);
      send(160, 34, 1, 0);
      send(223, 68, 0, 0);
      send(33, 136, 1, 1);
      wait_all_results();

      // size code above the maximum clamps to 32x32
      configure(MODE_DITHER, 0, 7);
      send(0, 255, 0, 0);
      send(255, 0, 0, 0);
      send(255, 0, 1, 1);
      wait_all_results();

      // unused mode code acts as fixed, at both extremes of the level
      configure(MODE_UNUSED, 255, 3);
      send(254, 0, 0, 0);
      send(255, 0, 1, 0);
      wait_all_results();
      write_reg(CSR_FIXED_LEVEL, 8'd0);
      @(negedge clock);
      send(0, 255, 0, 1);
      wait_all_results();

      configure(MODE_DITHER, 77, 6);
      send(128, 1, 0, 0);
      send(127, 2, 1, 0);
      wait_all_results();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         fixed = (p == 1) ? 0 : (p == 7) ? 255 : $urandom_range(255);
         configure(phase_mode[p], fixed, phase_log2[p]);
         calm = (p == 4);
         random_pixels(PHASE_ITEMS);
         wait_all_results();
         calm = 1'b0;
      end

      repeat (8) @(posedge clock);
      if (expected_out.size() != 0) begin
         mismatches++;
         $display("%0t: %0d results never arrived", $time, expected_out.size());
      end
      $display("Halftoned %0d pixels under %0d register settings: all mode codes,",
               req_total, settings_used + 1);
      $display("matrix sizes 2 to 32 with clamped size codes, raster phase wrap, %0d errors",
               mismatches);
      if (mismatches == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
